// ===== design/grbe_pkg.sv =====
package grbe_pkg;

   // field widths
   localparam int ACCEL_W     = 19;
   localparam int GYRO_W      = 22;
   localparam int BIAS_W      = 22;
   localparam int STATE_W     = 2;
   localparam int TALLY_W     = 13;
   localparam int RESTART_W   = 16;
   localparam int SUM_W       = 36;

   // configuration register widths
   localparam int TARGET_W    = 13;
   localparam int LIMIT_W     = 21;
   localparam int TOL_W       = 13;
   localparam int MAXB_W      = 21;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 2;

   // derived widths
   localparam int LOHI_W      = TOL_W + 1;
   localparam int SQ_W        = 2 * ACCEL_W;
   localparam int REM_W       = TALLY_W + 1;
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   // constants
   localparam int MAX_SAMPLES = 4096;
   localparam int ONE_G       = 8192;

   // configuration reset values
   localparam logic [TARGET_W-1:0] TARGET_RESET   = TARGET_W'(500);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = LIMIT_W'(3072);
   localparam logic [TOL_W-1:0]    TOL_RESET      = TOL_W'(819);
   localparam logic [MAXB_W-1:0]   MAX_BIAS_RESET = MAXB_W'(2048);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STILL_TARGET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_TOL    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BIAS     = 2'd3;

   typedef enum logic [STATE_W-1:0] {
      PH_COLLECTING = 2'd0,
      PH_DONE       = 2'd1,
      PH_REJECTED   = 2'd2
   } phase_type;

   // operand choice of the shared squarer
   typedef enum logic [2:0] {
      SQ_AX,
      SQ_AY,
      SQ_AZ,
      SQ_LO,
      SQ_HI
   } sq_sel_type;

   typedef struct packed {
      logic       load;
      logic       restart;
      logic       sq_step;
      sq_sel_type sq_sel;
      logic       apply;
      logic       div_load;
      logic       div_step;
      logic       div_finish;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic collecting;
      logic reached;
   } dp_stat_type;

endpackage

// ===== design/grbe_if.sv =====
interface grbe_req_if import grbe_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [ACCEL_W-1:0] accel_x;
   logic signed [ACCEL_W-1:0] accel_y;
   logic signed [ACCEL_W-1:0] accel_z;
   logic signed [GYRO_W-1:0]  gyro_x;
   logic signed [GYRO_W-1:0]  gyro_y;
   logic signed [GYRO_W-1:0]  gyro_z;

   modport source (output valid, req_type, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, input ready);
   modport sink   (input valid, req_type, accel_x, accel_y, accel_z,
                   gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface grbe_rsp_if import grbe_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [STATE_W-1:0]        estimate_state;
   logic signed [BIAS_W-1:0]  bias_x;
   logic signed [BIAS_W-1:0]  bias_y;
   logic signed [BIAS_W-1:0]  bias_z;
   logic [TALLY_W-1:0]        still_count;
   logic [RESTART_W-1:0]      restart_count;

   modport source (output valid, estimate_state, bias_x, bias_y, bias_z,
                   still_count, restart_count, input ready);
   modport sink   (input valid, estimate_state, bias_x, bias_y, bias_z,
                   still_count, restart_count, output ready);
endinterface

// ===== design/grbe_ctrl.sv =====
module grbe_ctrl import grbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   output logic        req_ready,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESTART,
      ST_SQUARE,
      ST_APPLY,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } ctrl_state_type;

   ctrl_state_type        state_ff, state_in;
   sq_sel_type            sel_ff, sel_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // sequence one word through the datapath
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.sq_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_type) begin
                  state_in = ST_RESTART;
               end else if (!stat.collecting) begin
                  state_in = ST_RESPOND;
               end else begin
                  state_in = ST_SQUARE;
                  sel_in   = SQ_AX;
               end
            end
         end
         ST_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = ST_RESPOND;
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            case (sel_ff)
               SQ_AX:   sel_in = SQ_AY;
               SQ_AY:   sel_in = SQ_AZ;
               SQ_AZ:   sel_in = SQ_LO;
               SQ_LO:   sel_in = SQ_HI;
               default: state_in = ST_APPLY;
            endcase
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.reached) begin
               cmd.div_load = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIVIDE;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.div_finish = 1'b1;
            state_in       = ST_RESPOND;
         end
         ST_RESPOND: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SQ_AX;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/grbe_datapath.sv =====
module grbe_datapath import grbe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wr_data,
   input  logic signed [ACCEL_W-1:0] accel_x,
   input  logic signed [ACCEL_W-1:0] accel_y,
   input  logic signed [ACCEL_W-1:0] accel_z,
   input  logic signed [GYRO_W-1:0]  gyro_x,
   input  logic signed [GYRO_W-1:0]  gyro_y,
   input  logic signed [GYRO_W-1:0]  gyro_z,
   input  dp_cmd_type                cmd,
   output dp_stat_type               stat,
   output logic [STATE_W-1:0]        estimate_state,
   output logic signed [BIAS_W-1:0]  bias_x,
   output logic signed [BIAS_W-1:0]  bias_y,
   output logic signed [BIAS_W-1:0]  bias_z,
   output logic [TALLY_W-1:0]        still_count,
   output logic [RESTART_W-1:0]      restart_count
);

   // configuration
   logic [TARGET_W-1:0] target_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [TOL_W-1:0]    tol_ff;
   logic [MAXB_W-1:0]   max_bias_ff;

   // captured sample
   logic signed [ACCEL_W-1:0] accel_ff [3];
   logic signed [GYRO_W-1:0]  gyro_ff  [3];

   // estimator state
   phase_type                phase_ff, phase_in;
   logic signed [SUM_W-1:0]  sum_ff   [3];
   logic signed [SUM_W-1:0]  sum_in   [3];
   logic [TALLY_W-1:0]       tally_ff, tally_in;
   logic [RESTART_W-1:0]     restart_ff, restart_in;
   logic signed [BIAS_W-1:0] bias_ff  [3];
   logic signed [BIAS_W-1:0] bias_in  [3];

   // squarer results
   logic [SQ_W-1:0] m2_ff, m2_in;
   logic [SQ_W-1:0] lo2_ff, lo2_in;
   logic [SQ_W-1:0] hi2_ff, hi2_in;

   // divider lanes
   logic [REM_W-1:0] rem_ff [3];
   logic [REM_W-1:0] rem_in [3];
   logic [SUM_W-1:0] quo_ff [3];
   logic [SUM_W-1:0] quo_in [3];
   logic             neg_ff [3];
   logic             neg_in [3];

   // output register
   logic [STATE_W-1:0]       out_state_ff, out_state_in;
   logic signed [BIAS_W-1:0] out_bias_ff [3];
   logic signed [BIAS_W-1:0] out_bias_in [3];
   logic [TALLY_W-1:0]       out_still_ff, out_still_in;
   logic [RESTART_W-1:0]     out_restart_ff, out_restart_in;

   logic [ACCEL_W-1:0]  acc_mag [3];
   logic [GYRO_W-1:0]   gyr_mag [3];
   logic [LOHI_W-1:0]   lo_val, hi_val;
   logic [ACCEL_W-1:0]  mul_op;
   logic [SQ_W-1:0]     prod;
   logic [TALLY_W-1:0]  target_eff;
   logic                still;
   logic                ok;
   logic [REM_W-1:0]    trial [3];
   logic [SUM_W-1:0]    sum_mag [3];
   logic [BIAS_W-1:0]   q_low [3];

   // magnitudes of the captured sample and the running sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_mag[i] = accel_ff[i][ACCEL_W-1] ? ACCEL_W'(-accel_ff[i]) : ACCEL_W'(accel_ff[i]);
         gyr_mag[i] = gyro_ff[i][GYRO_W-1] ? GYRO_W'(-gyro_ff[i]) : GYRO_W'(gyro_ff[i]);
         sum_mag[i] = sum_ff[i][SUM_W-1] ? SUM_W'(-sum_ff[i]) : SUM_W'(sum_ff[i]);
      end
   end

   // shared squarer operand
   assign lo_val = LOHI_W'(ONE_G) - {1'b0, tol_ff};
   assign hi_val = LOHI_W'(ONE_G) + {1'b0, tol_ff};

   always_comb begin
      case (cmd.sq_sel)
         SQ_AX:   mul_op = acc_mag[0];
         SQ_AY:   mul_op = acc_mag[1];
         SQ_AZ:   mul_op = acc_mag[2];
         SQ_LO:   mul_op = ACCEL_W'(lo_val);
         SQ_HI:   mul_op = ACCEL_W'(hi_val);
         default: mul_op = '0;
      endcase
   end

   assign prod = SQ_W'(mul_op) * SQ_W'(mul_op);

   // clamp the target into one to the sample limit
   always_comb begin
      if (target_ff == '0) begin
         target_eff = TALLY_W'(1);
      end else if (target_ff > TARGET_W'(MAX_SAMPLES)) begin
         target_eff = TALLY_W'(MAX_SAMPLES);
      end else begin
         target_eff = TALLY_W'(target_ff);
      end
   end

   // stillness test
   always_comb begin
      still = (m2_ff >= lo2_ff) && (m2_ff <= hi2_ff);
      for (int i = 0; i < 3; i++) begin
         if (gyr_mag[i] > GYRO_W'(limit_ff)) begin
            still = 1'b0;
         end
      end
   end

   // next state of the estimator, squarer and divider
   always_comb begin
      phase_in   = phase_ff;
      tally_in   = tally_ff;
      restart_in = restart_ff;
      m2_in      = m2_ff;
      lo2_in     = lo2_ff;
      hi2_in     = hi2_ff;
      ok         = 1'b1;
      for (int i = 0; i < 3; i++) begin
         sum_in[i]  = sum_ff[i];
         bias_in[i] = bias_ff[i];
         rem_in[i]  = rem_ff[i];
         quo_in[i]  = quo_ff[i];
         neg_in[i]  = neg_ff[i];
         trial[i]   = {rem_ff[i][TALLY_W-1:0], quo_ff[i][SUM_W-1]};
         q_low[i]   = quo_ff[i][BIAS_W-1:0];
      end

      // accumulate squares, then form the tolerance bounds
      if (cmd.sq_step) begin
         case (cmd.sq_sel)
            SQ_AX:   m2_in  = prod;
            SQ_AY:   m2_in  = m2_ff + prod;
            SQ_AZ:   m2_in  = m2_ff + prod;
            SQ_LO:   lo2_in = prod;
            SQ_HI:   hi2_in = prod;
            default: m2_in  = m2_ff;
         endcase
      end

      // restart request: clear the run, keep bias and restart tally
      if (cmd.restart) begin
         phase_in = PH_COLLECTING;
         tally_in = '0;
         for (int i = 0; i < 3; i++) begin
            sum_in[i] = '0;
         end
      end

      // add a still sample or drop the run on motion
      if (cmd.apply) begin
         if (still) begin
            tally_in = tally_ff + 1'b1;
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = sum_ff[i] + SUM_W'(gyro_ff[i]);
            end
         end else begin
            if (tally_ff != '0 && restart_ff != '1) begin
               restart_in = restart_ff + 1'b1;
            end
            tally_in = '0;
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = '0;
            end
         end
      end

      // restoring division of each sum magnitude by the tally
      if (cmd.div_load) begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = '0;
            quo_in[i] = sum_mag[i];
            neg_in[i] = sum_ff[i][SUM_W-1];
         end
      end
      if (cmd.div_step) begin
         for (int i = 0; i < 3; i++) begin
            if (trial[i] >= REM_W'(tally_ff)) begin
               rem_in[i] = trial[i] - REM_W'(tally_ff);
               quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i];
               quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
            end
         end
      end

      // restore the sign and judge the bias
      if (cmd.div_finish) begin
         for (int i = 0; i < 3; i++) begin
            bias_in[i] = neg_ff[i] ? $signed(-q_low[i]) : $signed(q_low[i]);
            if (quo_ff[i] > SUM_W'(max_bias_ff)) begin
               ok = 1'b0;
            end
         end
         phase_in = ok ? PH_DONE : PH_REJECTED;
      end
   end

   // output word, bias zeroed while collecting
   always_comb begin
      out_state_in   = out_state_ff;
      out_still_in   = out_still_ff;
      out_restart_in = out_restart_ff;
      for (int i = 0; i < 3; i++) begin
         out_bias_in[i] = out_bias_ff[i];
      end
      if (cmd.out_load) begin
         out_state_in   = phase_ff;
         out_still_in   = tally_ff;
         out_restart_in = restart_ff;
         for (int i = 0; i < 3; i++) begin
            out_bias_in[i] = (phase_ff == PH_COLLECTING) ? '0 : bias_ff[i];
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         limit_ff    <= LIMIT_RESET;
         tol_ff      <= TOL_RESET;
         max_bias_ff <= MAX_BIAS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STILL_TARGET: target_ff   <= csr_wr_data[TARGET_W-1:0];
            CSR_GYRO_LIMIT:   limit_ff    <= csr_wr_data[LIMIT_W-1:0];
            CSR_ACCEL_TOL:    tol_ff      <= csr_wr_data[TOL_W-1:0];
            CSR_MAX_BIAS:     max_bias_ff <= csr_wr_data[MAXB_W-1:0];
            default:          target_ff   <= target_ff;
         endcase
      end
   end

   // estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COLLECTING;
         tally_ff   <= '0;
         restart_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]  <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         phase_ff   <= phase_in;
         tally_ff   <= tally_in;
         restart_ff <= restart_in;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]  <= sum_in[i];
            bias_ff[i] <= bias_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         accel_ff[0] <= accel_x;
         accel_ff[1] <= accel_y;
         accel_ff[2] <= accel_z;
         gyro_ff[0]  <= gyro_x;
         gyro_ff[1]  <= gyro_y;
         gyro_ff[2]  <= gyro_z;
      end
      m2_ff          <= m2_in;
      lo2_ff         <= lo2_in;
      hi2_ff         <= hi2_in;
      out_state_ff   <= out_state_in;
      out_still_ff   <= out_still_in;
      out_restart_ff <= out_restart_in;
      for (int i = 0; i < 3; i++) begin
         rem_ff[i]      <= rem_in[i];
         quo_ff[i]      <= quo_in[i];
         neg_ff[i]      <= neg_in[i];
         out_bias_ff[i] <= out_bias_in[i];
      end
   end

   assign stat.collecting = (phase_ff == PH_COLLECTING);
   assign stat.reached    = (tally_ff >= target_eff);

   assign estimate_state = out_state_ff;
   assign bias_x         = out_bias_ff[0];
   assign bias_y         = out_bias_ff[1];
   assign bias_z         = out_bias_ff[2];
   assign still_count    = out_still_ff;
   assign restart_count  = out_restart_ff;

endmodule

// ===== design/gyro_residual_bias_estimator_unit.sv =====
// A word is accepted only after the previous one has been loaded into the output register. A still or
// motion sample runs the five passes of the shared squarer, and the sample that completes a run also
// runs the 36-step three-lane divider; restarts and samples after completion skip both.
// Reset (synchronous, active high) restores the register defaults, starts a new run with
// zero sums, tallies and bias, and empties the output register.
module gyro_residual_bias_estimator_unit import grbe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   grbe_req_if.sink               req_ch,
   grbe_rsp_if.source             rsp_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   grbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   grbe_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .accel_x        (req_ch.accel_x),
      .accel_y        (req_ch.accel_y),
      .accel_z        (req_ch.accel_z),
      .gyro_x         (req_ch.gyro_x),
      .gyro_y         (req_ch.gyro_y),
      .gyro_z         (req_ch.gyro_z),
      .cmd            (cmd),
      .stat           (stat),
      .estimate_state (rsp_ch.estimate_state),
      .bias_x         (rsp_ch.bias_x),
      .bias_y         (rsp_ch.bias_y),
      .bias_z         (rsp_ch.bias_z),
      .still_count    (rsp_ch.still_count),
      .restart_count  (rsp_ch.restart_count)
   );

endmodule

// ===== sim/tb.sv =====
module tb;
   import grbe_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int RESTART_FULL    = 65535;
   localparam int GYRO_MAX_POS    = 2097151;
   localparam int GYRO_MIN_NEG    = -2097152;

   typedef struct packed {
      logic                      req_type;
      logic signed [ACCEL_W-1:0] ax;
      logic signed [ACCEL_W-1:0] ay;
      logic signed [ACCEL_W-1:0] az;
      logic signed [GYRO_W-1:0]  gx;
      logic signed [GYRO_W-1:0]  gy;
      logic signed [GYRO_W-1:0]  gz;
   } imu_word_type;

   typedef struct packed {
      phase_type                state;
      logic signed [BIAS_W-1:0] bx;
      logic signed [BIAS_W-1:0] by;
      logic signed [BIAS_W-1:0] bz;
      logic [TALLY_W-1:0]       still_count;
      logic [RESTART_W-1:0]     restart_count;
   } estimate_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   grbe_req_if req_ch ();
   grbe_rsp_if rsp_ch ();

   gyro_residual_bias_estimator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // predicted configuration and estimator state
   longint    cfg_target, cfg_limit, cfg_tol, cfg_maxb;
   phase_type est_phase;
   longint    est_sum [3];
   longint    est_bias [3];
   int        est_tally;
   int        est_restarts;

   estimate_type pending_estimates [$];
   int        mismatch_count;
   int        words_sent;
   int        quiet_cycles;
   int        hold_requests;
   bit        idle_on;
   int        run_center [3];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int rand_between(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic longint magnitude_of(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int effective_target();
      if (cfg_target == 0) return 1;
      if (cfg_target > MAX_SAMPLES) return MAX_SAMPLES;
      return int'(cfg_target);
   endfunction

   // Advance the predicted estimator by one word and queue its result.
   function automatic void predict_estimate(input imu_word_type w);
      longint       accel_v [3];
      longint       gyro_v [3];
      longint       mag2, lo, hi;
      bit           still, in_limit;
      estimate_type want;
      accel_v[0] = $signed(w.ax);
      accel_v[1] = $signed(w.ay);
      accel_v[2] = $signed(w.az);
      gyro_v[0]  = $signed(w.gx);
      gyro_v[1]  = $signed(w.gy);
      gyro_v[2]  = $signed(w.gz);
      if (w.req_type) begin
         est_phase = PH_COLLECTING;
         est_tally = 0;
         for (int i = 0; i < 3; i++) est_sum[i] = 0;
      end else if (est_phase == PH_COLLECTING) begin
         mag2 = 0;
         for (int i = 0; i < 3; i++) mag2 += accel_v[i] * accel_v[i];
         lo = ONE_G - cfg_tol;
         hi = ONE_G + cfg_tol;
         still = (mag2 >= lo * lo) && (mag2 <= hi * hi);
         for (int i = 0; i < 3; i++)
            if (magnitude_of(gyro_v[i]) > cfg_limit) still = 1'b0;
         if (!still) begin
            // motion breaks the run
            if (est_tally != 0 && est_restarts < RESTART_FULL) est_restarts++;
            est_tally = 0;
            for (int i = 0; i < 3; i++) est_sum[i] = 0;
         end else begin
            for (int i = 0; i < 3; i++) est_sum[i] += gyro_v[i];
            est_tally++;
            if (est_tally >= effective_target()) begin
               in_limit = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  est_bias[i] = est_sum[i] / est_tally;
                  if (magnitude_of(est_bias[i]) > cfg_maxb) in_limit = 1'b0;
               end
               if (in_limit) est_phase = PH_DONE;
               else          est_phase = PH_REJECTED;
            end
         end
      end
      want.state = est_phase;
      if (est_phase == PH_COLLECTING) begin
         want.bx = '0;
         want.by = '0;
         want.bz = '0;
      end else begin
         want.bx = BIAS_W'(est_bias[0]);
         want.by = BIAS_W'(est_bias[1]);
         want.bz = BIAS_W'(est_bias[2]);
      end
      want.still_count   = TALLY_W'(est_tally);
      want.restart_count = RESTART_W'(est_restarts);
      pending_estimates.push_back(want);
   endfunction

   // ---------------- word builders ----------------

   function automatic imu_word_type make_word(input bit rt, input int ax, input int ay,
                                              input int az, input int gx, input int gy,
                                              input int gz);
      imu_word_type w;
      w.req_type = rt;
      w.ax = ACCEL_W'(ax);
      w.ay = ACCEL_W'(ay);
      w.az = ACCEL_W'(az);
      w.gx = GYRO_W'(gx);
      w.gy = GYRO_W'(gy);
      w.gz = GYRO_W'(gz);
      return w;
   endfunction

   function automatic imu_word_type noise_word();
      imu_word_type w;
      w.req_type = ($urandom_range(0, 7) == 0);
      w.ax = ACCEL_W'($urandom);
      w.ay = ACCEL_W'($urandom);
      w.az = ACCEL_W'($urandom);
      w.gx = GYRO_W'($urandom);
      w.gy = GYRO_W'($urandom);
      w.gz = GYRO_W'($urandom);
      return w;
   endfunction

   function automatic imu_word_type restart_word();
      imu_word_type w;
      w = noise_word();
      w.req_type = 1'b1;
      return w;
   endfunction

   // Pick per-axis rate offsets for the next run: some small, some anywhere within the limit.
   function automatic void new_run_center();
      int lim;
      lim = int'(cfg_limit);
      for (int i = 0; i < 3; i++) begin
         run_center[i] = rand_between(-lim, lim);
         if ($urandom_range(0, 1)) run_center[i] = run_center[i] / 64;
      end
   endfunction

   // Accel near 1 g on one axis, rates around the run center within the limit.
   function automatic imu_word_type still_word();
      int acc [3];
      int gyr [3];
      int dev, side, lim, spread, main_axis;
      dev  = int'(cfg_tol) / 2;
      side = int'(cfg_tol) / 4;
      for (int i = 0; i < 3; i++) acc[i] = rand_between(-side, side);
      main_axis = $urandom_range(0, 2);
      acc[main_axis] = ONE_G + rand_between(-dev, dev);
      if ($urandom_range(0, 1)) acc[main_axis] = -acc[main_axis];
      lim    = int'(cfg_limit);
      spread = lim / 8;
      for (int i = 0; i < 3; i++) begin
         gyr[i] = run_center[i] + rand_between(-spread, spread);
         if (gyr[i] > lim)  gyr[i] = lim;
         if (gyr[i] < -lim) gyr[i] = -lim;
      end
      return make_word(1'b0, acc[0], acc[1], acc[2], gyr[0], gyr[1], gyr[2]);
   endfunction

   // Break stillness by rate over the limit, too little or too much accel.
   function automatic imu_word_type motion_word();
      imu_word_type w;
      int axis, lo, hi, g;
      w    = still_word();
      axis = $urandom_range(0, 2);
      lo   = ONE_G - int'(cfg_tol);
      hi   = ONE_G + int'(cfg_tol);
      case ($urandom_range(0, 3))
         0: begin
            if (cfg_limit < GYRO_MAX_POS) begin
               g = rand_between(int'(cfg_limit) + 1, GYRO_MAX_POS);
               if ($urandom_range(0, 1)) g = -g;
            end else begin
               g = GYRO_MIN_NEG;
            end
            if (axis == 0)      w.gx = GYRO_W'(g);
            else if (axis == 1) w.gy = GYRO_W'(g);
            else                w.gz = GYRO_W'(g);
         end
         1: begin
            w.gx = GYRO_W'(GYRO_MIN_NEG);
         end
         2: begin
            w.ax = ACCEL_W'(rand_between(0, lo - 1));
            w.ay = '0;
            w.az = '0;
         end
         default: begin
            w.ax = '0;
            w.ay = '0;
            w.az = ACCEL_W'(-rand_between(hi + 1, 262143));
         end
      endcase
      return w;
   endfunction

   // ---------------- drivers ----------------

   // Offer one word, hold it until accepted, then maybe idle.
   task automatic send_word(input imu_word_type w);
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= w.req_type;
      req_ch.accel_x  <= w.ax;
      req_ch.accel_y  <= w.ay;
      req_ch.accel_z  <= w.az;
      req_ch.gyro_x   <= w.gx;
      req_ch.gyro_y   <= w.gy;
      req_ch.gyro_z   <= w.gz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_estimate(w);
      words_sent++;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every queued estimate has come back.
   task automatic wait_for_estimates();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Write all four registers; the narrow ones get random upper bits.
   task automatic set_config(input int target, input int limit, input int tol,
                             input int maxb);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      data[TARGET_W-1:0] = TARGET_W'(target);
      csr_write(CSR_STILL_TARGET, data);
      cfg_target = data[TARGET_W-1:0];
      data = CSR_DATA_W'(limit);
      csr_write(CSR_GYRO_LIMIT, data);
      cfg_limit = data[LIMIT_W-1:0];
      data = CSR_DATA_W'($urandom);
      data[TOL_W-1:0] = TOL_W'(tol);
      csr_write(CSR_ACCEL_TOL, data);
      cfg_tol = data[TOL_W-1:0];
      data = CSR_DATA_W'(maxb);
      csr_write(CSR_MAX_BIAS, data);
      cfg_maxb = data[MAXB_W-1:0];
      csr_wr_en <= 1'b0;
   endtask

   // ---------------- result side ----------------

   // Accept results, with random stall bursts and one long hold-off on request.
   initial begin : result_receiver
      int hold_seen;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("estimate mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin : check_estimate
      estimate_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_estimates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: state %0d still_count %0d",
                        rsp_ch.estimate_state, rsp_ch.still_count);
         end else begin
            want = pending_estimates.pop_front();
            check_field("estimate_state", want.state, rsp_ch.estimate_state);
            check_field("bias_x", want.bx, rsp_ch.bias_x);
            check_field("bias_y", want.by, rsp_ch.bias_y);
            check_field("bias_z", want.bz, rsp_ch.bias_z);
            check_field("still_count", want.still_count, rsp_ch.still_count);
            check_field("restart_count", want.restart_count, rsp_ch.restart_count);
         end
      end
   end

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("** gyro_residual_bias_estimator_unit: FAILED **");
         $finish;
      end
   end

   // ---------------- tests ----------------

   // Boundaries of stillness, truncation, completion, ignored words, restarts.
   task automatic test_directed();
      set_config(3, 1000, 100, 500);
      send_word(make_word(1'b0, 8092, 0, 0, 1000, -1000, -1));
      send_word(make_word(1'b0, 0, -8292, 0, 0, 0, 0));
      send_word(make_word(1'b0, 0, 0, 8293, 0, 0, 0));
      send_word(make_word(1'b0, 8192, 0, 0, -1001, 0, 0));
      send_word(make_word(1'b0, 8192, 0, 0, 1000, -1000, -1));
      send_word(make_word(1'b0, -8192, 0, 0, 1000, -1000, -1));
      send_word(make_word(1'b0, 0, 8192, 0, 1000, -999, 0));
      send_word(make_word(1'b0, 0, 8192, 0, 0, 0, 0));
      send_word(make_word(1'b0, 0, 0, 0, 0, 0, 0));
      send_word(restart_word());
      send_word(restart_word());
      send_word(make_word(1'b0, 8192, 0, 0, GYRO_MIN_NEG, 0, 0));
      send_word(make_word(1'b0, -262144, 262143, 0, GYRO_MAX_POS, GYRO_MAX_POS,
                          GYRO_MIN_NEG));
      wait_for_estimates();
      // zero target acts as one, widest limits
      set_config(0, GYRO_MAX_POS, 8191, GYRO_MAX_POS);
      send_word(make_word(1'b0, 0, 0, 8192, 5, -7, GYRO_MAX_POS));
      send_word(restart_word());
      send_word(make_word(1'b0, 1, 0, 0, -GYRO_MAX_POS, 0, 0));
      send_word(restart_word());
      send_word(make_word(1'b0, 0, 0, 16383, GYRO_MIN_NEG, 0, 0));
      send_word(make_word(1'b0, 0, 16384, 0, 0, 0, 0));
      wait_for_estimates();
   endtask

   // Hold the result side off while words keep coming, then pause the sender.
   task automatic test_backpressure();
      set_config(6, 3000, 819, 1500);
      send_word(restart_word());
      new_run_center();
      hold_requests <= hold_requests + 1;
      for (int k = 0; k < 48; k++) begin
         if (k % 9 == 8) send_word(motion_word());
         else            send_word(still_word());
      end
      wait_for_estimates();
      for (int k = 0; k < 20; k++) send_word(still_word());
      wait_for_estimates();
   endtask

   // Mostly well-formed runs with random content, plus noise, under several settings.
   task automatic test_random_settings();
      int limit, stop_at, n, kind;
      for (int s = 0; s < 8; s++) begin
         case (s)
            0: set_config(0, GYRO_MAX_POS, 8191, 0);
            1: set_config(1, 0, 0, GYRO_MAX_POS);
            default: begin
               if ($urandom_range(0, 1)) limit = $urandom_range(0, 4096);
               else                      limit = $urandom_range(0, GYRO_MAX_POS);
               set_config($urandom_range(2, 24), limit, $urandom_range(0, 8191),
                          $urandom_range(0, limit));
            end
         endcase
         stop_at = words_sent + 150;
         while (words_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               new_run_center();
               n = effective_target();
               for (int k = 0; k < n; k++) begin
                  if ($urandom_range(0, 39) == 0)      send_word(motion_word());
                  else if ($urandom_range(0, 59) == 0) send_word(noise_word());
                  send_word(still_word());
               end
               repeat ($urandom_range(0, 2))
                  send_word($urandom_range(0, 1) ? still_word() : motion_word());
               send_word(restart_word());
            end else if (kind < 85) begin
               send_word(motion_word());
            end else if (kind < 93) begin
               send_word(noise_word());
            end else begin
               send_word(restart_word());
            end
         end
         wait_for_estimates();
      end
   endtask

   // A target above the sample limit keeps collecting through a long still run.
   task automatic test_target_clamp();
      set_config(8191, GYRO_MAX_POS, 8191, GYRO_MAX_POS);
      send_word(restart_word());
      new_run_center();
      repeat (150) send_word(still_word());
      send_word(restart_word());
      wait_for_estimates();
   endtask

   // Break short runs back to back and count every restart.
   task automatic test_restart_breaks();
      idle_on = 1'b0;
      set_config(MAX_SAMPLES, 100, 819, 2048);
      send_word(restart_word());
      new_run_center();
      for (int k = 0; k < 40; k++) begin
         send_word(still_word());
         send_word(motion_word());
      end
      wait_for_estimates();
   endtask

   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_STILL_TARGET;
      csr_wr_data     = '0;
      req_ch.valid    = 1'b0;
      req_ch.req_type = 1'b0;
      req_ch.accel_x  = '0;
      req_ch.accel_y  = '0;
      req_ch.accel_z  = '0;
      req_ch.gyro_x   = '0;
      req_ch.gyro_y   = '0;
      req_ch.gyro_z   = '0;
      cfg_target      = TARGET_RESET;
      cfg_limit       = LIMIT_RESET;
      cfg_tol         = TOL_RESET;
      cfg_maxb        = MAX_BIAS_RESET;
      est_phase       = PH_COLLECTING;
      est_tally       = 0;
      est_restarts    = 0;
      for (int i = 0; i < 3; i++) begin
         est_sum[i]    = 0;
         est_bias[i]   = 0;
         run_center[i] = 0;
      end
      mismatch_count = 0;
      words_sent     = 0;
      quiet_cycles   = 0;
      hold_requests  = 0;
      idle_on        = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random_settings();
      test_target_clamp();
      test_restart_breaks();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_estimates.size() == 0) begin
         $display("** gyro_residual_bias_estimator_unit: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  pending_estimates.size());
         $display("** gyro_residual_bias_estimator_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/grbe_pkg.sv
design/grbe_if.sv
design/grbe_ctrl.sv
design/grbe_datapath.sv
design/gyro_residual_bias_estimator_unit.sv
sim/tb.sv
